// ===== src/mada_pkg.sv =====
package mada_pkg;

  localparam int WINDOW   = 10;
  localparam int SAMPLE_W = 10;
  localparam int SCALE_W  = 12;
  localparam int DEV_W    = 10;
  localparam int HOLD_W   = 4;
  localparam int TEMP_W   = 14;
  localparam int FRAC_W   = 8;
  localparam int CFG_W    = 12;

  localparam int PROD_W   = SAMPLE_W + SCALE_W;
  localparam int SHIFT_W  = PROD_W - FRAC_W;
  localparam int TEMP_MAX = (1 << TEMP_W) - 1;
  localparam int SUM_MAX  = WINDOW * TEMP_MAX;
  localparam int SUM_W    = $clog2(SUM_MAX + 1);
  localparam int CMP_W    = SUM_W + 2;
  localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Division by WINDOW as a multiply by a rounded-up reciprocal; exact for
  // every SUM_W-bit dividend.
  localparam int DIV_L    = $clog2(WINDOW);
  localparam int DIV_S    = SUM_W + DIV_L;
  localparam longint DIV_M_L = ((64'd1 << DIV_S) + WINDOW - 1) / WINDOW;
  localparam int DIV_M_W  = SUM_W + 1;
  localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_L[DIV_M_W-1:0];
  localparam int DIV_P_W  = SUM_W + DIV_M_W;

  typedef enum logic [1:0] {
    CFG_SCALE = 2'd0,
    CFG_DEV   = 2'd1,
    CFG_HOLD  = 2'd2
  } cfg_idx_t;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(826);
  localparam logic [DEV_W-1:0]   DEV_RST   = DEV_W'(20);
  localparam logic [HOLD_W-1:0]  HOLD_RST  = HOLD_W'(4);

  function automatic logic [TEMP_W-1:0] avg_of(input logic [SUM_W-1:0] sum);
    logic [DIV_P_W-1:0] prod;
    prod = DIV_P_W'(sum) * DIV_P_W'(DIV_M);
    return prod[DIV_S +: TEMP_W];
  endfunction

endpackage

// ===== src/moving_average_deviation_alarm_unit.sv =====
// Channel | Direction | Ports                                   | Handshake
// input   | in        | in_sample                               | in_valid / in_ready
// result  | out       | out_temp_tenths, out_prev_tenths,       | out_valid / out_ready
//         |           | out_prev2_tenths, out_avg_tenths,       |
//         |           | out_alarm_active, out_alert_start       |
// config  | in        | cfg_index, cfg_wdata                    | cfg_we, no wait
// One sample per cycle is taken while the output is not stalled.
// The sample window sits in a small synchronous memory read in stage a, one stage
// before the running sum update in stage b; stages a, b and c feed an output register.
// Synchronous active-low reset clears the window valid flags, sum, alarm, hold counter and
// history, and loads the register defaults; there is no clearing pass.
// A stalled output stalls only the stages behind a full stage, so bubbles collapse.
module moving_average_deviation_alarm_unit
  import mada_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TEMP_W-1:0]   out_temp_tenths,
  output logic [TEMP_W-1:0]   out_prev_tenths,
  output logic [TEMP_W-1:0]   out_prev2_tenths,
  output logic [TEMP_W-1:0]   out_avg_tenths,
  output logic                out_alarm_active,
  output logic                out_alert_start,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  logic [SCALE_W-1:0] scale_r;
  logic [DEV_W-1:0]   dev_r;
  logic [HOLD_W-1:0]  hold_cnt_r;

  logic [TEMP_W-1:0]  win_mem [WINDOW];
  logic [WINDOW-1:0]  win_vld_r;
  logic [TEMP_W-1:0]  rd_r;
  logic [IDX_W-1:0]   rd_idx_r;

  logic               a_valid_r;
  logic [PROD_W-1:0]  a_prod_r;

  logic               b_valid_r;
  logic [TEMP_W-1:0]  b_temp_r;
  logic [CMP_W-1:0]   b_tlo_r;
  logic [CMP_W-1:0]   b_thi_r;
  logic [IDX_W-1:0]   b_idx_r;
  logic               b_old_vld_r;

  logic [SUM_W-1:0]   sum_r;
  logic               alarm_r;
  logic [HOLD_W-1:0]  hold_r;

  logic               c_valid_r;
  logic [TEMP_W-1:0]  c_temp_r;
  logic [SUM_W-1:0]   c_sum_r;
  logic               c_dec_r;
  logic               c_alarm_r;
  logic               c_alert_r;

  logic               out_valid_r;
  logic [TEMP_W-1:0]  out_temp_r;
  logic [TEMP_W-1:0]  out_prev_r;
  logic [TEMP_W-1:0]  out_prev2_r;
  logic [TEMP_W-1:0]  out_avg_r;
  logic               out_alarm_r;
  logic               out_alert_r;

  logic               out_load;
  logic               c_free;
  logic               b_move;
  logic               b_free;
  logic               a_move;
  logic               in_xfer;

  logic [SHIFT_W-1:0] shifted;
  logic [TEMP_W-1:0]  temp_sat;
  logic [CMP_W-1:0]   tw;
  logic [CMP_W-1:0]   dw;
  logic [IDX_W-1:0]   rd_idx_nxt;

  logic [TEMP_W-1:0]  old_val;
  logic [SUM_W-1:0]   sum_nxt;
  logic               dec;
  logic               alarm_cmp;
  logic               alarm_nxt;
  logic [HOLD_W-1:0]  hold_inc;
  logic [HOLD_W-1:0]  hold_nxt;

  logic               a_valid_nxt;
  logic               b_valid_nxt;
  logic               c_valid_nxt;
  logic               out_valid_nxt;

  // Stage flow control.
  always_comb begin
    out_load      = c_valid_r && (!out_valid_r || out_ready);
    c_free        = !c_valid_r || out_load;
    b_move        = b_valid_r && c_free;
    b_free        = !b_valid_r || b_move;
    a_move        = a_valid_r && b_free;
    in_ready      = !a_valid_r || a_move;
    in_xfer       = in_valid && in_ready;
    a_valid_nxt   = in_xfer || (a_valid_r && !a_move);
    b_valid_nxt   = a_move || (b_valid_r && !b_move);
    c_valid_nxt   = b_move || (c_valid_r && !out_load);
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  // Scaling and comparison bounds for the sample leaving the first stage.
  always_comb begin
    shifted    = a_prod_r[PROD_W-1:FRAC_W];
    temp_sat   = (32'(shifted) > TEMP_MAX) ? TEMP_W'(TEMP_MAX) : TEMP_W'(shifted);
    tw         = CMP_W'(temp_sat) * CMP_W'(WINDOW);
    dw         = CMP_W'(dev_r) * CMP_W'(WINDOW);
    rd_idx_nxt = (32'(rd_idx_r) == WINDOW - 1) ? '0 : rd_idx_r + IDX_W'(1);
  end

  // Running sum, decision and hold counter.
  always_comb begin
    old_val   = b_old_vld_r ? rd_r : '0;
    sum_nxt   = sum_r - SUM_W'(old_val) + SUM_W'(b_temp_r);
    dec       = (hold_r == '0);
    alarm_cmp = ($signed(b_tlo_r) > $signed({2'b00, sum_nxt}))
             || ($signed(b_thi_r) < $signed({2'b00, sum_nxt}));
    alarm_nxt = dec ? alarm_cmp : alarm_r;
    hold_inc  = hold_r + HOLD_W'(1);
    hold_nxt  = hold_r;
    if (alarm_nxt) begin
      hold_nxt = (hold_inc == hold_cnt_r) ? '0 : hold_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= SCALE_RST;
      dev_r      <= DEV_RST;
      hold_cnt_r <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCALE: scale_r    <= cfg_wdata[SCALE_W-1:0];
        CFG_DEV:   dev_r      <= cfg_wdata[DEV_W-1:0];
        CFG_HOLD:  hold_cnt_r <= cfg_wdata[HOLD_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      rd_r <= win_mem[rd_idx_r];
    end
    if (b_move) begin
      win_mem[b_idx_r] <= b_temp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rd_idx_r    <= '0;
      win_vld_r   <= '0;
      sum_r       <= '0;
      alarm_r     <= 1'b0;
      hold_r      <= '0;
      out_temp_r  <= '0;
      out_prev_r  <= '0;
      out_prev2_r <= '0;
      out_avg_r   <= '0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      b_valid_r   <= b_valid_nxt;
      c_valid_r   <= c_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (a_move) begin
        rd_idx_r <= rd_idx_nxt;
      end
      if (b_move) begin
        win_vld_r[b_idx_r] <= 1'b1;
        sum_r              <= sum_nxt;
        alarm_r            <= alarm_nxt;
        hold_r             <= hold_nxt;
      end
      if (out_load) begin
        out_temp_r  <= c_temp_r;
        out_prev_r  <= out_temp_r;
        out_prev2_r <= out_prev_r;
        if (c_dec_r) begin
          out_avg_r <= avg_of(c_sum_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_prod_r <= PROD_W'(in_sample) * PROD_W'(scale_r);
    end
    if (a_move) begin
      b_temp_r    <= temp_sat;
      b_tlo_r     <= tw - dw;
      b_thi_r     <= tw + dw;
      b_idx_r     <= rd_idx_r;
      b_old_vld_r <= win_vld_r[rd_idx_r];
    end
    if (b_move) begin
      c_temp_r  <= b_temp_r;
      c_sum_r   <= sum_nxt;
      c_dec_r   <= dec;
      c_alarm_r <= alarm_nxt;
      c_alert_r <= alarm_nxt && dec;
    end
    if (out_load) begin
      out_alarm_r <= c_alarm_r;
      out_alert_r <= c_alert_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_temp_tenths  = out_temp_r;
  assign out_prev_tenths  = out_prev_r;
  assign out_prev2_tenths = out_prev2_r;
  assign out_avg_tenths   = out_avg_r;
  assign out_alarm_active = out_alarm_r;
  assign out_alert_start  = out_alert_r;

  a_hold_needs_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_r != '0) |-> alarm_r)
    else $error("hold counter running without alarm");

  a_alert_implies_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r && c_alert_r) |-> (c_alarm_r && c_dec_r))
    else $error("alert start without alarm decision");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sum_r) <= SUM_MAX)
    else $error("running sum exceeds window bound");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rd_idx_r) < WINDOW)
    else $error("window index out of range");

  a_transfer_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> a_valid_r)
    else $error("accepted sample lost at first stage");

endmodule
